// ----- sv/ffm_pkg.sv -----
package ffm_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REQ_PUSH  = 1'b0,
    REQ_FLUSH = 1'b1
  } req_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] occupancy;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic next_idx;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search;
    logic match;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/fifo_flush_through_match.sv -----
// Flow: a push item, or a flush item to an empty queue, goes from S_IDLE to S_DONE; a
// flush item to a non-empty queue passes S_READ and S_CMP once per entry compared,
// comparing k entries (1..occupancy) from the oldest on, until a match or the last one.
// Throughput: one item at a time. in_stall stays high from acceptance until S_DONE loads
// the output register, so a result still waiting there also holds the input.
// Reset: synchronous active-low rst_n empties the queue and drops any pending result;
// entry storage is not cleared.
module fifo_flush_through_match #(
  parameter int QUEUE_DEPTH = ffm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ffm_pkg::out_item_t out_item
);
  import ffm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ffm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffm_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- sv/ffm_datapath.sv -----
module ffm_datapath #(
  parameter int QUEUE_DEPTH = ffm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffm_pkg::in_item_t   in_item,
  input  ffm_pkg::ctrl_cmd_t  cmd,
  output ffm_pkg::dp_stat_t   stat,
  input  logic                out_stall,
  output logic                out_valid,
  output ffm_pkg::out_item_t  out_item
);
  import ffm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  logic signed [31:0] mem [QUEUE_DEPTH];

  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   idx_r, idx_nxt;
  logic signed [31:0] val_r;
  logic signed [31:0] rdata_r;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r;

  logic               full;
  logic               empty;
  logic               wr_en;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   head_after;
  logic [CNT_W-1:0]   drop;

  // sum below twice the depth, folded back into range
  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] adj;
    adj = (sum >= SUM_W'(QUEUE_DEPTH)) ? sum - SUM_W'(QUEUE_DEPTH) : sum;
    return adj[PTR_W-1:0];
  endfunction

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  assign tail       = wrap(SUM_W'(head_r) + SUM_W'(count_r));
  assign rd_addr    = wrap(SUM_W'(head_r) + SUM_W'(idx_r));
  assign drop       = CNT_W'(idx_r) + CNT_W'(1);
  assign head_after = wrap(SUM_W'(head_r) + SUM_W'(idx_r) + SUM_W'(1));
  assign wr_en      = cmd.accept && (in_item.req_type == REQ_PUSH) && !full;

  assign stat.search   = (in_item.req_type == REQ_FLUSH) && !empty;
  assign stat.match    = (rdata_r == val_r);
  assign stat.last     = (drop == count_r);
  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    if (cmd.accept) begin
      idx_nxt = '0;
      if (in_item.req_type == REQ_PUSH) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt  = count_r + CNT_W'(1);
          status_nxt = ST_OK;
        end
      end else if (empty) begin
        status_nxt = ST_EMPTY;
      end
    end
    if (cmd.next_idx) begin
      idx_nxt = idx_r + PTR_W'(1);
    end
    if (cmd.commit) begin
      if (stat.match) begin
        // drop the matching entry and everything older
        head_nxt   = head_after;
        count_nxt  = count_r - drop;
        status_nxt = ST_OK;
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    if (cmd.accept) begin
      val_r <= in_item.value;
    end
    if (cmd.load_out) begin
      out_item_r.status    <= status_r;
      out_item_r.occupancy <= 4'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= in_item.value;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- sv/ffm_ctrl.sv -----
module ffm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffm_pkg::dp_stat_t  stat,
  output ffm_pkg::ctrl_cmd_t cmd
);
  import ffm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.search ? S_READ : S_DONE;
        end
      end
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        state_nxt = (stat.match || stat.last) ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_READ: cmd.rd_en = 1'b1;
      S_CMP: begin
        cmd.commit   = stat.match || stat.last;
        cmd.next_idx = !(stat.match || stat.last);
      end
      S_DONE: cmd.load_out = stat.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/ffm_checker.sv -----
module ffm_checker #(
  parameter int QUEUE_DEPTH = ffm_pkg::QUEUE_DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ffm_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input ffm_pkg::out_item_t out_item
);
  import ffm_pkg::*;

  localparam logic [3:0] DEPTH4 = 4'(QUEUE_DEPTH);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted item");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |-> out_item.occupancy == DEPTH4)
    else $error("full status without full occupancy");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_EMPTY |-> out_item.occupancy == 4'd0)
    else $error("empty status with nonzero occupancy");

endmodule

bind fifo_flush_through_match ffm_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_ffm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ----- tb/sv/fifo_flush_through_match_tb.sv -----
module fifo_flush_through_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffm_pkg::*;

  localparam int DEPTH        = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 + 2 * DEPTH + 20;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        cycles = 0;

  class flush_queue_scoreboard;
    logic [31:0] held[$];
    out_item_t   want_q[$];
    int          errors = 0;

    function void note_request(in_item_t it);
      out_item_t res;
      int        hit;
      hit = -1;
      res = '0;
      if (it.req_type == REQ_PUSH) begin
        if (held.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held.push_back(it.value);
          res.status = ST_OK;
        end
      end else if (held.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // oldest match wins; newer duplicates stay queued
        foreach (held[i]) if (hit < 0 && held[i] == it.value) hit = i;
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          repeat (hit + 1) void'(held.pop_front());
          res.status = ST_OK;
        end
      end
      res.occupancy = 4'(held.size());
      want_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual status %0d occupancy %0d",
                 $time, got.status, got.occupancy);
        return;
      end
      want = want_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch expected %0d actual %0d",
                 $time, want.status, got.status);
      end
      if (got.occupancy !== want.occupancy) begin
        errors++;
        $display("%0t: occupancy mismatch expected %0d actual %0d",
                 $time, want.occupancy, got.occupancy);
      end
    endfunction
  endclass

  flush_queue_scoreboard sb;

  fifo_flush_through_match DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // result side backpressure: calm, light and heavy stretches
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (cycles % 256 == 0) mode = $urandom_range(0, 2);
      if (left > 0) begin
        left--;
      end else if (mode != 0 && $urandom_range(0, 99) < (mode == 1 ? 20 : 40)) begin
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      end
      out_stall <= (left > 0);
    end
  end

  function automatic in_item_t mk(req_t r, logic [31:0] v);
    in_item_t it;
    it.req_type = r;
    it.value    = v;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    // small pool makes duplicates and hits likely
    if (r < 4) return 32'($urandom_range(0, 6) - 3);
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  function automatic in_item_t pick_request(bit filling);
    in_item_t it;
    int       n;
    n = sb.held.size();
    it = mk(REQ_PUSH, pick_value());
    if ($urandom_range(0, 99) >= (filling ? 75 : 35)) begin
      it.req_type = REQ_FLUSH;
      if (n > 0 && $urandom_range(0, 9) < 8) it.value = sb.held[$urandom_range(0, n - 1)];
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(in_item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(it);
    @(negedge clk);
  endtask

  initial begin
    in_item_t dir[$];
    sb = new();
    dir = '{
      mk(REQ_FLUSH, 32'h0000_0000),  // empty queue
      mk(REQ_PUSH,  32'h8000_0000),
      mk(REQ_PUSH,  32'h7fff_ffff),
      mk(REQ_PUSH,  32'h0000_0000),
      mk(REQ_PUSH,  32'hffff_ffff),
      mk(REQ_PUSH,  32'h0000_0005),
      mk(REQ_PUSH,  32'h7fff_ffff),
      mk(REQ_PUSH,  32'h0000_0007),
      mk(REQ_PUSH,  32'h8000_0000),  // now full
      mk(REQ_PUSH,  32'h0000_0009),  // push when full
      mk(REQ_FLUSH, 32'h0000_3039),  // no match
      mk(REQ_FLUSH, 32'h7fff_ffff),  // oldest copy only
      mk(REQ_FLUSH, 32'h8000_0000),  // newest entry, empties
      mk(REQ_FLUSH, 32'hffff_ffff),
      mk(REQ_PUSH,  32'haaaa_aaaa),
      mk(REQ_PUSH,  32'h5555_5555),
      mk(REQ_FLUSH, 32'haaaa_aaab),
      mk(REQ_FLUSH, 32'h5555_5555),
      mk(REQ_PUSH,  32'h0000_0001),
      mk(REQ_FLUSH, 32'h0000_0001)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir[i]) send_request(dir[i], pick_gap());

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (sb.want_q.size() != 0) @(negedge clk);
      end
      send_request(pick_request(((k / 40) % 2) == 0), (k % 200 < 50) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    while (sb.want_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ffm_pkg.sv
sv/ffm_datapath.sv
sv/ffm_ctrl.sv
sv/fifo_flush_through_match.sv
sv/ffm_checker.sv
tb/sv/fifo_flush_through_match_tb.sv
